// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on clk_i, off while rst_ni is low
`define TSPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check sampled on clk_i that also holds during reset
`define TSPP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/tspp_pkg.sv =====
// types and constants of the transport stream packet parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tspp_pkg;

  localparam int unsigned PACKET_BYTES = 188;
  localparam int unsigned PID_COUNT    = 8192;
  localparam int unsigned PID_W        = $clog2(PID_COUNT);
  localparam int unsigned FIFO_DEPTH   = 8;
  localparam int unsigned TDATA_W      = 144;

  localparam logic [7:0] SYNC_BYTE     = 8'h47;
  localparam logic [7:0] ADAPT_MAX     = 8'd183;
  localparam logic [7:0] PCR_MIN_ALEN  = 8'd7;
  localparam logic [7:0] PCR_RSVD_MASK = 8'h7E;
  localparam logic [8:0] PCR_EXT_MAX   = 9'd299;
  localparam logic [8:0] PCR_MULT      = 9'd300;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_TRANSPORT     = 4'd0,
    ERR_SCRAMBLED     = 4'd1,
    ERR_RESERVED_AFC  = 4'd2,
    ERR_ADAPT_LONG    = 4'd3,
    ERR_ADAPT_ONLY    = 4'd4,
    ERR_PAYLOAD_EMPTY = 4'd5,
    ERR_PCR_TRUNC     = 4'd6,
    ERR_PCR_RSVD      = 4'd7,
    ERR_PCR_EXT       = 4'd8,
    ERR_CONTINUITY    = 4'd9
  } err_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   data_byte;
    logic [63:0]  packet_offset;
    logic [12:0]  pid;
    logic         unit_start;
    logic [3:0]   cont_count;
    logic         discontinuity;
    logic         pcr_present;
    logic [41:0]  pcr_value;
    logic [3:0]   error_code;
  } result_t;

  // one continuity table entry
  typedef struct packed {
    logic       valid;
    logic [3:0] cc;
  } ct_entry_t;

  // parser to continuity table requests
  typedef struct packed {
    logic             rd_en;
    logic [PID_W-1:0] rd_pid;
    logic             wr_en;
    logic [PID_W-1:0] wr_pid;
    ct_entry_t        wr_data;
  } ct_req_t;

endpackage

// ===== src/tspp_cc_table.sv =====
// per-pid continuity counter table with a clearing pass after reset
// depends on tspp_pkg
`timescale 1ns / 1ps

module tspp_cc_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tspp_pkg::ct_req_t   req_i,
  output tspp_pkg::ct_entry_t rd_data_o,
  output logic                busy_o
);
  import tspp_pkg::*;

  ct_entry_t        mem [PID_COUNT];
  ct_entry_t        rd_q;
  logic             busy_q, busy_d;
  logic [PID_W-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == PID_W'(PID_COUNT - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // one write port shared by the clearing sweep and counter updates
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_pid] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_pid];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

// ===== src/tspp_parse.sv =====
// byte parser: input register, header, adaptation and pcr checks, result build
// depends on tspp_pkg; reads and updates tspp_cc_table
`timescale 1ns / 1ps

module tspp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  tspp_pkg::ct_entry_t ct_rd_i,
  output tspp_pkg::ct_req_t   ct_req_o,
  output logic                push0_o,
  output logic                push1_o,
  output tspp_pkg::result_t   res0_o,
  output tspp_pkg::result_t   res1_o
);
  import tspp_pkg::*;

  // input register
  logic        stg_valid_q;
  logic [7:0]  stg_byte_q;

  // packet state
  logic [63:0] offset_q, offset_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  b1_q, b2_q, b3_q;
  logic [63:0] pkt_off_q;
  logic [7:0]  alen_q;
  logic [41:0] pcr_q;
  logic        err_v_q;
  err_e        err_code_q;
  logic [7:0]  aflags_q;

  // values after this byte
  logic        is_start, live, last, pay;
  logic [7:0]  b;
  logic [7:0]  c_b1, c_b2, c_b3, c_alen, c_af;
  logic [63:0] c_off;
  logic [41:0] c_pcr;
  logic        c_ev;
  err_e        c_ec;
  logic [1:0]  afc;
  logic        has_adapt, has_pay, pcr_on;
  logic [32:0] pcr_base;
  logic [8:0]  pcr_ext;
  logic [41:0] pcr_scaled;
  logic [8:0]  start9, idx9;
  logic [3:0]  cc_expect;
  logic [12:0] pid;
  result_t     pay_res, end_res;

  always_comb begin
    b        = stg_byte_q;
    is_start = (pos_q == 8'd0);
    live     = stg_valid_q && (!is_start || (b == SYNC_BYTE));
    idx9     = {1'b0, pos_q};

    c_b1   = (pos_q == 8'd1) ? b : (is_start ? 8'd0 : b1_q);
    c_b2   = (pos_q == 8'd2) ? b : (is_start ? 8'd0 : b2_q);
    c_b3   = (pos_q == 8'd3) ? b : (is_start ? 8'd0 : b3_q);
    c_off  = is_start ? offset_q : pkt_off_q;
    c_alen = is_start ? 8'd0 : alen_q;
    c_pcr  = is_start ? 42'd0 : pcr_q;
    c_ev   = is_start ? 1'b0 : err_v_q;
    c_ec   = is_start ? ERR_TRANSPORT : err_code_q;
    c_af   = is_start ? 8'd0 : aflags_q;

    afc       = c_b3[5:4];
    has_adapt = afc[1];
    has_pay   = afc[0];

    // header and adaptation field checks, first error wins
    if (!c_ev) begin
      if (pos_q == 8'd1 && b[7]) begin
        c_ev = 1'b1;
        c_ec = ERR_TRANSPORT;
      end
      if (pos_q == 8'd3) begin
        if (b[7:6] != 2'b00) begin
          c_ev = 1'b1;
          c_ec = ERR_SCRAMBLED;
        end else if (afc == 2'b00) begin
          c_ev = 1'b1;
          c_ec = ERR_RESERVED_AFC;
        end
      end
      if (pos_q == 8'd4 && has_adapt) begin
        c_alen = b;
        if (b > ADAPT_MAX) begin
          c_ev = 1'b1;
          c_ec = ERR_ADAPT_LONG;
        end else if (!has_pay && b != ADAPT_MAX) begin
          c_ev = 1'b1;
          c_ec = ERR_ADAPT_ONLY;
        end else if (has_pay && b == ADAPT_MAX) begin
          c_ev = 1'b1;
          c_ec = ERR_PAYLOAD_EMPTY;
        end
      end
      if (pos_q == 8'd5 && has_adapt && c_alen != 8'd0) begin
        c_af = b;
        if (b[4] && c_alen < PCR_MIN_ALEN) begin
          c_ev = 1'b1;
          c_ec = ERR_PCR_TRUNC;
        end
      end
    end

    pcr_on     = has_adapt && (c_alen != 8'd0) && c_af[4];
    pcr_base   = c_pcr[39:7];
    pcr_ext    = {c_pcr[0], b};
    pcr_scaled = pcr_base * PCR_MULT;

    // pcr gathering: five bytes of base and reserved bits, then the extension
    if (!c_ev && pcr_on) begin
      if (pos_q >= 8'd6 && pos_q <= 8'd10) begin
        c_pcr = {2'b00, c_pcr[31:0], b};
        if (pos_q == 8'd10 && (b & PCR_RSVD_MASK) != PCR_RSVD_MASK) begin
          c_ev = 1'b1;
          c_ec = ERR_PCR_RSVD;
        end
      end else if (pos_q == 8'd11) begin
        if (pcr_ext > PCR_EXT_MAX) begin
          c_ev = 1'b1;
          c_ec = ERR_PCR_EXT;
        end else begin
          c_pcr = pcr_scaled + 42'(pcr_ext);
        end
      end
    end

    if (!has_pay) begin
      start9 = 9'(PACKET_BYTES);
    end else if (has_adapt) begin
      start9 = 9'(c_alen) + 9'd5;
    end else begin
      start9 = 9'd4;
    end

    // continuity check on the byte just before the payload, or on the last byte when there is none
    cc_expect = has_pay ? (ct_rd_i.cc + 4'd1) : ct_rd_i.cc;
    if (!c_ev && pos_q >= 8'd3 && (idx9 + 9'd1) == start9 && !c_af[7] && ct_rd_i.valid &&
        c_b3[3:0] != cc_expect) begin
      c_ev = 1'b1;
      c_ec = ERR_CONTINUITY;
    end

    pid  = {c_b1[4:0], c_b2};
    pay  = live && !c_ev && has_pay && idx9 >= start9 && pos_q >= 8'd4;
    last = live && (pos_q == 8'(PACKET_BYTES - 1));

    pay_res.kind          = KIND_PAYLOAD;
    pay_res.data_byte     = b;
    pay_res.packet_offset = c_off;
    pay_res.pid           = pid;
    pay_res.unit_start    = c_b1[6];
    pay_res.cont_count    = c_b3[3:0];
    pay_res.discontinuity = c_af[7];
    pay_res.pcr_present   = pcr_on;
    pay_res.pcr_value     = pcr_on ? c_pcr : 42'd0;
    pay_res.error_code    = 4'd0;

    end_res               = pay_res;
    end_res.data_byte     = 8'd0;
    if (c_ev) begin
      end_res.kind          = KIND_ERROR;
      end_res.discontinuity = 1'b0;
      end_res.pcr_present   = 1'b0;
      end_res.pcr_value     = 42'd0;
      end_res.error_code    = c_ec;
    end else begin
      end_res.kind = KIND_SUMMARY;
    end

    ct_req_o.rd_en   = live && (pos_q == 8'd2);
    ct_req_o.rd_pid  = pid;
    ct_req_o.wr_en   = last && !c_ev;
    ct_req_o.wr_pid  = pid;
    ct_req_o.wr_data = '{valid: 1'b1, cc: c_b3[3:0]};

    push0_o = pay || last;
    push1_o = pay && last;
    res0_o  = pay ? pay_res : end_res;
    res1_o  = end_res;

    offset_d = stg_valid_q ? offset_q + 64'd1 : offset_q;
    pos_d    = pos_q;
    if (live) begin
      pos_d = last ? 8'd0 : pos_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      offset_q    <= '0;
      pos_q       <= '0;
    end else begin
      stg_valid_q <= in_valid_i;
      offset_q    <= offset_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      stg_byte_q <= in_byte_i;
    end
    if (live) begin
      b1_q       <= c_b1;
      b2_q       <= c_b2;
      b3_q       <= c_b3;
      pkt_off_q  <= c_off;
      alen_q     <= c_alen;
      pcr_q      <= c_pcr;
      err_v_q    <= c_ev;
      err_code_q <= c_ec;
      aflags_q   <= c_af;
    end
  end

endmodule

// ===== src/tspp_out_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one
// depends on tspp_pkg
`timescale 1ns / 1ps

module tspp_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push0_i,
  input  logic              push1_i,
  input  tspp_pkg::result_t res0_i,
  input  tspp_pkg::result_t res1_i,
  input  logic              pop_i,
  output logic              valid_o,
  output tspp_pkg::result_t head_o,
  output logic              room_o
);
  import tspp_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nxt;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_nxt = wr_ptr_q + 1'b1;
    wr_ptr_d   = wr_ptr_q + PTR_W'(push0_i) + PTR_W'(push1_i);
    rd_ptr_d   = rd_ptr_q + PTR_W'(pop_i);
    count_d    = count_q + CNT_W'(push0_i) + CNT_W'(push1_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nxt] <= res1_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // room for the byte in flight plus a new one, each giving up to two results
  assign room_o  = (count_q <= CNT_W'(FIFO_DEPTH - 4));

endmodule

// ===== src/ts_packet_parser_top.sv =====
// transport stream packet parser, top level
// depends on tspp_pkg, tspp_parse, tspp_cc_table, tspp_out_fifo
//
// Input stream: one raw transport stream byte per transfer on s_axis.
// Output stream: one result per transfer on m_axis; tuser holds the kind
// (payload byte, good packet summary, rejected packet with error code) and
// tdata the packet fields listed at the port.
// Bytes before a 0x47 sync are dropped; then 188 bytes form one packet.
// Payload bytes of a good packet stream out as they arrive, and the last
// byte of the packet yields a summary or an error result.
// Each byte passes the input register; its results then enter the result queue.
// Throughput: one byte per cycle while s_axis_tready is high; the last byte of
// a packet may produce two results, which an eight-entry result queue absorbs.
// Reset: the control state clears and the 8192-entry continuity table is swept,
// one entry a cycle; s_axis_tready stays low until the sweep is done.
// Receiver stall: results wait in the queue; s_axis_tready drops once more
// than four results are queued, so nothing is lost.
`timescale 1ns / 1ps

module ts_packet_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [71:8] packet_offset, [84:72] pid, [85] unit_start,
  // [89:86] cont_count, [90] discontinuity, [91] pcr_present,
  // [133:92] pcr_value, [137:134] error_code, [143:138] zero
  output logic [tspp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import tspp_pkg::*;

  logic      in_xfer, pop, push0, push1, room, ct_busy;
  result_t   res0, res1, head;
  ct_req_t   ct_req;
  ct_entry_t ct_rd;

  assign s_axis_tready = room && !ct_busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  tspp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_xfer),
    .in_byte_i  (s_axis_tdata),
    .ct_rd_i    (ct_rd),
    .ct_req_o   (ct_req),
    .push0_o    (push0),
    .push1_o    (push1),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  tspp_cc_table u_cc_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ct_req),
    .rd_data_o (ct_rd),
    .busy_o    (ct_busy)
  );

  tspp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .res0_i  (res0),
    .res1_i  (res1),
    .pop_i   (pop),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .room_o  (room)
  );

  assign m_axis_tdata = {6'b0, head.error_code, head.pcr_value, head.pcr_present,
                         head.discontinuity, head.cont_count, head.unit_start,
                         head.pid, head.packet_offset, head.data_byte};
  assign m_axis_tuser = head.kind;

endmodule

// ===== src/tspp_checker.sv =====
// port-level checks of the transport stream packet parser, bound to the top
// depends on tspp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tspp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [7:0]                   s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tspp_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser
);
  import tspp_pkg::*;

  localparam int unsigned PCR_PRESENT_BIT = 91;

  logic       in_xfer;
  logic [7:0] data_byte;
  logic [41:0] pcr_value;
  logic [3:0] error_code;

  assign in_xfer    = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
  assign data_byte  = m_axis_tdata[7:0];
  assign pcr_value  = m_axis_tdata[133:92];
  assign error_code = m_axis_tdata[137:134];

  // nothing offered or taken while rst_ni is low
  `TSPP_ASSERT_RST(a_reset_quiet, !rst_ni |-> !m_axis_tvalid && !in_xfer, "active during reset")

  `TSPP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `TSPP_ASSERT(a_good_no_code, m_axis_tvalid && m_axis_tuser != KIND_ERROR |-> error_code == 4'd0, "error code on a good result")

  `TSPP_ASSERT(a_err_clean, m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> data_byte == 8'd0 && !m_axis_tdata[PCR_PRESENT_BIT], "rejected packet carries data")

  `TSPP_ASSERT(a_pcr_zero, m_axis_tvalid && !m_axis_tdata[PCR_PRESENT_BIT] |-> pcr_value == 42'd0, "pcr value without pcr")

endmodule

bind ts_packet_parser_top tspp_checker u_tspp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
